// File: sv/grpc_message_deframer_top_macros.svh
// Assertion macros for the gRPC message deframer RTL.
// Depends on a clk and an active-low rst_n in the including scope.
`ifndef GRPC_MESSAGE_DEFRAMER_TOP_MACROS_SVH
`define GRPC_MESSAGE_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset
`define GMD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define GMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/gmd_pkg.sv
// Package for the gRPC message deframer: widths, opcodes, result kinds and
// the per-stream state word. No dependencies.
`default_nettype none

package gmd_pkg;

    // Sizing
    localparam int STREAM_SLOTS_DEFAULT = 8;
    localparam int INDEX_W = 3;
    localparam int LIMIT_W = 25;
    localparam int LEN_W   = 32;
    // Prefix plus payload count; never passes message_limit (a 25-bit value)
    localparam int SEEN_W  = 25;

    localparam int PREFIX_BYTES = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_FLOOR = LIMIT_W'(4096);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(65536);

    // Opcodes
    localparam logic [1:0] OP_OPEN = 2'd0;
    localparam logic [1:0] OP_DATA = 2'd1;
    localparam logic [1:0] OP_END  = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_EMPTY    = 2'd1;
    localparam logic [1:0] KIND_OVERSIZE = 2'd2;
    localparam logic [1:0] KIND_END      = 2'd3;

    // Per-stream state word kept in the state RAM
    typedef struct packed {
        logic              live;
        logic [SEEN_W-1:0] seen;
        logic [LEN_W-1:0]  decl;
    } gmd_state_t;

endpackage

`default_nettype wire

// File: sv/gmd_state_ram.sv
// Per-stream state RAM for the deframer: one write and one registered read
// port, with per-entry valid flops so unwritten entries read as zero. Uses gmd_pkg.
`default_nettype none

module gmd_state_ram
    import gmd_pkg::*;
#(
    parameter int DEPTH  = STREAM_SLOTS_DEFAULT,
    parameter int ADDR_W = 3
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output gmd_state_t             rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire gmd_state_t        wr_data
);

    gmd_state_t             mem [DEPTH];
    logic [DEPTH-1:0]       entry_valid_reg;
    gmd_state_t             rd_word_reg;
    logic                   rd_valid_reg;

    // Storage array, read-old on a same-address collision
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // Entry valid bits: an entry reads as zero until first written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                entry_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= entry_valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

`default_nettype wire

// File: sv/grpc_message_deframer_top.sv
// gRPC message deframer: takes one byte-stream word per cycle and returns at
// most one result word. The input is registered into the state RAM read and a
// one-deep update stage; results sit in an output register, so a new word is
// accepted while a finished result still waits. Throughput is one word per
// clock while in_ready holds, set by the per-stream read-modify-write of the
// state RAM (registered read, with the write-back forwarded to a back-to-back
// word on the same stream). A result passes through the update stage, then the
// output register; in_ready drops only while that register is full and not taken.
// Per stream: a 5-byte prefix (flag byte, 32-bit big-endian length), then
// the payload bytes; message_limit bounds prefix plus payload (floor 4096).
// Uses gmd_pkg, gmd_state_ram and grpc_message_deframer_top_macros.svh.
`default_nettype none
`include "grpc_message_deframer_top_macros.svh"

module grpc_message_deframer_top
    import gmd_pkg::*;
#(
    parameter int STREAM_SLOTS = STREAM_SLOTS_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Configuration write
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [LIMIT_W-1:0] message_limit,
    // Input words
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         opcode,
    input  wire logic [INDEX_W-1:0] stream_index,
    input  wire logic [7:0]         data_byte,
    input  wire logic               response_ok,
    // Result words
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [INDEX_W-1:0]      result_stream,
    output logic [1:0]              result_kind,
    output logic [7:0]              payload_byte,
    output logic                    message_last,
    output logic                    partial_message
);

    localparam int SLOT_W = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;

    // Limit register
    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] limit_next;

    // Update stage
    logic               s1_valid_reg;
    logic [1:0]         s1_op_reg;
    logic [SLOT_W-1:0]  s1_addr_reg;
    logic [INDEX_W-1:0] s1_index_reg;
    logic [7:0]         s1_byte_reg;
    logic               s1_ok_reg;
    logic               s1_in_range_reg;

    // Forwarding of the previous write-back
    logic               fwd_hit_reg;
    logic               fwd_hit_next;
    gmd_state_t         fwd_state_reg;

    // Output register
    logic               out_valid_reg;
    logic [INDEX_W-1:0] result_stream_reg;
    logic [1:0]         result_kind_reg;
    logic [7:0]         payload_byte_reg;
    logic               message_last_reg;
    logic               partial_message_reg;

    logic               in_accept;
    logic               in_range;
    logic [SLOT_W-1:0]  in_addr;
    logic [SLOT_W-1:0]  rd_addr;
    gmd_state_t         ram_rdata;
    gmd_state_t         cur;
    gmd_state_t         new_state;
    logic               s1_wr;
    logic               s1_emit;
    logic               s1_adv;
    logic               out_free;
    logic [1:0]         s1_kind;
    logic [7:0]         s1_obyte;
    logic               s1_last;
    logic               s1_partial;
    logic [LEN_W-1:0]   decl_shift;
    logic [LEN_W:0]     prefix_total;
    logic [LEN_W:0]     msg_end;
    logic [SEEN_W-1:0]  seen_inc;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign s1_adv    = s1_valid_reg && (!s1_emit || out_free);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign in_accept = in_valid && in_ready;

    // Slot decode; out-of-range slots read entry zero and never write
    assign in_range = (32'(stream_index) < STREAM_SLOTS);
    assign in_addr  = SLOT_W'(stream_index);
    assign rd_addr  = in_range ? in_addr : '0;

    // Limit with its floor
    always_comb
    begin
        limit_next = limit_reg;
        if (cfg_valid && cfg_ready)
        begin
            limit_next = (message_limit < LIMIT_FLOOR) ? LIMIT_FLOOR : message_limit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    // State RAM
    gmd_state_ram #(
        .DEPTH  (STREAM_SLOTS),
        .ADDR_W (SLOT_W)
    ) u_state_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata),
        .wr_en   (s1_adv && s1_wr),
        .wr_addr (s1_addr_reg),
        .wr_data (new_state)
    );

    // Current state: RAM data, or the write-back that the RAM read missed
    assign cur = fwd_hit_reg ? fwd_state_reg : ram_rdata;

    // Length arithmetic
    assign decl_shift   = (cur.seen != '0) ? {cur.decl[LEN_W-9:0], s1_byte_reg} : cur.decl;
    assign prefix_total = {1'b0, decl_shift} + (LEN_W+1)'(PREFIX_BYTES);
    assign msg_end      = {1'b0, cur.decl} + (LEN_W+1)'(PREFIX_BYTES);
    assign seen_inc     = cur.seen + SEEN_W'(1);

    // Next state and result of the word in the update stage
    always_comb
    begin
        new_state  = cur;
        s1_wr      = 1'b0;
        s1_emit    = 1'b0;
        s1_kind    = KIND_PAYLOAD;
        s1_obyte   = 8'd0;
        s1_last    = 1'b0;
        s1_partial = 1'b0;
        if (s1_valid_reg && s1_in_range_reg)
        begin
            unique case (s1_op_reg)
                OP_OPEN:
                begin
                    s1_wr          = 1'b1;
                    new_state      = '0;
                    new_state.live = 1'b1;
                end
                OP_END:
                begin
                    if (cur.live)
                    begin
                        s1_wr      = 1'b1;
                        new_state  = '0;
                        s1_emit    = s1_ok_reg;
                        s1_kind    = KIND_END;
                        s1_partial = (cur.seen != '0);
                    end
                end
                OP_DATA:
                begin
                    if (cur.live && s1_ok_reg)
                    begin
                        s1_wr = 1'b1;
                        if (cur.seen < SEEN_W'(PREFIX_BYTES))
                        begin
                            // Prefix byte: flag first, then the length MSB first
                            new_state.decl = decl_shift;
                            new_state.seen = seen_inc;
                            if (cur.seen == SEEN_W'(PREFIX_BYTES - 1))
                            begin
                                if (prefix_total > (LEN_W+1)'(limit_reg))
                                begin
                                    new_state = '0;
                                    s1_emit   = 1'b1;
                                    s1_kind   = KIND_OVERSIZE;
                                end
                                else if (decl_shift == '0)
                                begin
                                    new_state.seen = '0;
                                    s1_emit        = 1'b1;
                                    s1_kind        = KIND_EMPTY;
                                end
                            end
                        end
                        else
                        begin
                            // Payload byte
                            new_state.seen = seen_inc;
                            s1_emit        = 1'b1;
                            s1_obyte       = s1_byte_reg;
                            if ((LEN_W+1)'(seen_inc) >= msg_end)
                            begin
                                s1_last        = 1'b1;
                                new_state.seen = '0;
                                new_state.decl = '0;
                            end
                        end
                    end
                end
                default:
                begin
                    s1_wr = 1'b0;
                end
            endcase
        end
    end

    // A word read on the same edge as a write to its slot takes the new state
    assign fwd_hit_next = in_accept && s1_adv && s1_wr && in_range && (in_addr == s1_addr_reg);

    // Update stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= fwd_hit_next;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
                fwd_hit_reg  <= 1'b0;
            end
        end
    end

    // Update stage payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg       <= opcode;
            s1_addr_reg     <= rd_addr;
            s1_index_reg    <= stream_index;
            s1_byte_reg     <= data_byte;
            s1_ok_reg       <= response_ok;
            s1_in_range_reg <= in_range;
            fwd_state_reg   <= new_state;
        end
    end

    // Output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv && s1_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_emit)
        begin
            result_stream_reg   <= s1_index_reg;
            result_kind_reg     <= s1_kind;
            payload_byte_reg    <= s1_obyte;
            message_last_reg    <= s1_last;
            partial_message_reg <= s1_partial;
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_stream   = result_stream_reg;
    assign result_kind     = result_kind_reg;
    assign payload_byte    = payload_byte_reg;
    assign message_last    = message_last_reg;
    assign partial_message = partial_message_reg;

    // Checks
    `GMD_ASSERT_NOW(a_stall_only_when_full, !in_ready,
        s1_valid_reg && out_valid_reg && !out_ready, "input stalled without a full output")
    `GMD_ASSERT_NOW(a_partial_only_end, out_valid_reg && partial_message_reg,
        result_kind_reg == KIND_END, "partial flag on a result other than stream end")
    `GMD_ASSERT_NOW(a_last_only_payload, out_valid_reg && message_last_reg,
        result_kind_reg == KIND_PAYLOAD, "last flag on a result other than payload")
    `GMD_ASSERT_NOW(a_result_slot_range, out_valid_reg,
        32'(result_stream_reg) < STREAM_SLOTS, "result for a slot out of range")
    `GMD_ASSERT_NEXT(a_forward_taken, fwd_hit_next,
        s1_valid_reg && fwd_hit_reg, "write-back not forwarded to same-slot word")

endmodule

`default_nettype wire
